@@ rtl/core/swdc_pkg.sv @@
// ----------------------------------------------------------------------------
// swdc_pkg
// Shared types and constants of the sliding-window distinct counter.
// ----------------------------------------------------------------------------
package swdc_pkg;

   // item kinds
   localparam logic KIND_PUSH  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // register indexes (byte address 4*i)
   localparam logic REG_WINDOW_LENGTH    = 1'b0;
   localparam logic REG_UNIQUE_THRESHOLD = 1'b1;

   // register reset values
   localparam logic [7:0]  WINDOW_LENGTH_RESET    = 8'd100;
   localparam logic [16:0] UNIQUE_THRESHOLD_RESET = 17'd6554;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic cmp_en;    // capture compare results
      logic shift_en;  // shift the row by one place
      logic clear;     // empty the row
      logic evict;     // the oldest key leaves with this item
   } swdc_ctrl_type;

   // flags handed from one cell to the next
   typedef struct packed {
      logic valid;     // cell holds a key of the window
      logic dup;       // a newer copy of the same key is in the window
   } swdc_flag_type;

endpackage

@@ rtl/core/swdc_cell.sv @@
// ----------------------------------------------------------------------------
// swdc_cell
// One window slot: holds a key, compares it to the current key and shifts
// its contents to the next slot when a key is pushed.
// ----------------------------------------------------------------------------
module swdc_cell
   import swdc_pkg::*;
#(
   parameter int KEY_BITS   = 32,
   parameter int IDX_BITS   = 7,
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  swdc_ctrl_type       ctrl,
   input  logic [KEY_BITS-1:0] cmd_key,
   input  logic [IDX_BITS-1:0] oldest_idx,
   input  logic [KEY_BITS-1:0] prev_key,
   input  swdc_flag_type       prev_flag,
   output logic [KEY_BITS-1:0] next_key,
   output swdc_flag_type       next_flag,
   output logic                match,
   output logic                drop
);

   logic [KEY_BITS-1:0] key_ff;
   logic                valid_ff;
   logic                dup_ff;
   logic                match_ff;
   logic                sel_ff;
   logic                drop_ff;
   logic                is_oldest;

   // this slot holds the key that leaves the window
   assign is_oldest = ctrl.evict && (oldest_idx == IDX_BITS'(CELL_INDEX));

   // capture compare results for the pending item
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         sel_ff   <= 1'b0;
         drop_ff  <= 1'b0;
      end else if (ctrl.cmp_en) begin
         match_ff <= valid_ff && (key_ff == cmd_key) && !is_oldest;
         sel_ff   <= is_oldest;
         drop_ff  <= is_oldest && valid_ff && !dup_ff;
      end
   end

   // shift the slot contents, drop the evicted key on the way
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dup_ff   <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
         dup_ff   <= 1'b0;
      end else if (ctrl.shift_en) begin
         valid_ff <= prev_flag.valid;
         dup_ff   <= prev_flag.dup;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         key_ff <= prev_key;
      end
   end

   // a key that matches the pushed key now has a newer copy
   assign next_key        = key_ff;
   assign next_flag.valid = valid_ff && !sel_ff;
   assign next_flag.dup   = dup_ff || match_ff;
   assign match           = match_ff;
   assign drop            = drop_ff;

endmodule

@@ rtl/core/sliding_window_distinct_counter_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_distinct_counter_unit
// Sliding window of recent keys with a distinct-key count and a save latch.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one item per transfer: kind selects a push of
//   event_key or a clear of window, counts and latch. Every item gives one
//   transfer on the rsp channel with the latch, distinct count and fill as
//   they stand after the item.
//   The window is a row of cells shifted on each push; every cell compares
//   its key with the pushed key and a two-level OR tree collects the hits.
//   An item passes through compare, first tree level, then second tree level
//   together with the update before rsp_valid rises, and a new item is
//   taken only once the one before it has left the update state.
//   A finished result waits in the rsp slot; the next item is accepted
//   meanwhile and holds in its update cycle until the slot is taken.
//   Reset empties the window, zeroes the counts, drops the latch and loads
//   window_length = 100 and unique_threshold = 6554.
//   Registers (APB, byte address 4*i): 0 window_length, 1 unique_threshold.
//   Write them only while no item is in flight.
// ----------------------------------------------------------------------------
module sliding_window_distinct_counter_unit
   import swdc_pkg::*;
#(
   parameter int WINDOW_MAX = 128,
   parameter int KEY_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_event_key,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_save_states,
   output logic [7:0]  rsp_distinct_count,
   output logic [7:0]  rsp_window_fill,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int LW = (CW > 8) ? CW : 8;
   localparam int PW = 17 + LW;
   localparam int NG = (WINDOW_MAX + 7) / 8;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CMP  = 4'b0010,
      ST_RED  = 4'b0100,
      ST_UPD  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [7:0]          window_length_ff;
   logic [16:0]         unique_threshold_ff;
   logic                cmd_kind_ff;
   logic [KEY_BITS-1:0] cmd_key_ff;
   logic                evict_ff;
   logic [IW-1:0]       oldest_ff;
   logic [LW-1:0]       len_ff;
   logic [PW-1:0]       prod_ff;
   logic [CW-1:0]       fill_ff;
   logic [CW-1:0]       distinct_ff;
   logic                latch_ff;
   logic                rsp_valid_ff;
   logic [NG-1:0]       grp_hit_ff, grp_hit_in;
   logic [NG-1:0]       grp_drop_ff, grp_drop_in;

   logic                req_xfer;
   logic                cfg_wr;
   logic                upd_go;
   logic [LW-1:0]       len_eff;
   logic                evict_in;
   logic                hit_any;
   logic                drop_any;
   logic [CW-1:0]       fill_new;
   logic [CW-1:0]       distinct_new;
   logic [PW-1:0]       lhs;
   swdc_ctrl_type       ctrl;

   logic [KEY_BITS-1:0]   link_key  [0:WINDOW_MAX];
   swdc_flag_type         link_flag [0:WINDOW_MAX];
   logic [WINDOW_MAX-1:0] match_vec;
   logic [WINDOW_MAX-1:0] drop_vec;

   // configuration registers
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff    <= WINDOW_LENGTH_RESET;
         unique_threshold_ff <= UNIQUE_THRESHOLD_RESET;
      end else if (cfg_wr) begin
         case (paddr[2])
            REG_WINDOW_LENGTH:    window_length_ff    <= pwdata[7:0];
            REG_UNIQUE_THRESHOLD: unique_threshold_ff <= pwdata[16:0];
            default:              window_length_ff    <= window_length_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_WINDOW_LENGTH:    prdata = 32'(window_length_ff);
         REG_UNIQUE_THRESHOLD: prdata = 32'(unique_threshold_ff);
         default:              prdata = '0;
      endcase
   end

   // clamp the window length to 1..WINDOW_MAX
   always_comb begin
      if (window_length_ff == 8'd0) begin
         len_eff = LW'(1);
      end else if (LW'(window_length_ff) > LW'(WINDOW_MAX)) begin
         len_eff = LW'(WINDOW_MAX);
      end else begin
         len_eff = LW'(window_length_ff);
      end
   end

   assign evict_in = (LW'(fill_ff) >= len_eff) && (fill_ff != '0);

   // sequencer
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign upd_go    = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = req_xfer ? ST_CMP : ST_IDLE;
         ST_CMP:  state_in = ST_RED;
         ST_RED:  state_in = ST_UPD;
         ST_UPD:  state_in = upd_go ? ST_IDLE : ST_UPD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the item and its per-item constants
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_kind_ff <= req_kind;
         cmd_key_ff  <= KEY_BITS'(req_event_key);
         evict_ff    <= evict_in;
         oldest_ff   <= IW'(fill_ff - CW'(1));
         len_ff      <= len_eff;
         prod_ff     <= PW'(unique_threshold_ff) * PW'(len_eff);
      end
   end

   // broadcast control to the row
   assign ctrl.cmp_en   = (state_ff == ST_CMP);
   assign ctrl.shift_en = upd_go && (cmd_kind_ff == KIND_PUSH);
   assign ctrl.clear    = upd_go && (cmd_kind_ff == KIND_CLEAR);
   assign ctrl.evict    = evict_ff && (cmd_kind_ff == KIND_PUSH);

   // row of window cells, newest key enters at cell 0
   assign link_key[0]        = cmd_key_ff;
   assign link_flag[0].valid = 1'b1;
   assign link_flag[0].dup   = 1'b0;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swdc_cell #(
         .KEY_BITS   (KEY_BITS),
         .IDX_BITS   (IW),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cmd_key    (cmd_key_ff),
         .oldest_idx (oldest_ff),
         .prev_key   (link_key[i]),
         .prev_flag  (link_flag[i]),
         .next_key   (link_key[i+1]),
         .next_flag  (link_flag[i+1]),
         .match      (match_vec[i]),
         .drop       (drop_vec[i])
      );
   end

   // first tree level: OR groups of eight cells
   always_comb begin
      grp_hit_in  = '0;
      grp_drop_in = '0;
      for (int g = 0; g < NG; g++) begin
         for (int j = 0; j < 8; j++) begin
            if (g * 8 + j < WINDOW_MAX) begin
               grp_hit_in[g]  = grp_hit_in[g]  | match_vec[g*8+j];
               grp_drop_in[g] = grp_drop_in[g] | drop_vec[g*8+j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_hit_ff  <= grp_hit_in;
      grp_drop_ff <= grp_drop_in;
   end

   // second tree level and counter update
   assign hit_any      = |grp_hit_ff;
   assign drop_any     = |grp_drop_ff;
   assign fill_new     = fill_ff - CW'(evict_ff) + CW'(1);
   assign distinct_new = distinct_ff - CW'(drop_any) + CW'(!hit_any);
   assign lhs          = PW'(distinct_new) << 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         distinct_ff <= '0;
         latch_ff    <= 1'b0;
      end else if (ctrl.clear) begin
         fill_ff     <= '0;
         distinct_ff <= '0;
         latch_ff    <= 1'b0;
      end else if (ctrl.shift_en) begin
         fill_ff     <= fill_new;
         distinct_ff <= distinct_new;
         if (!latch_ff && (LW'(fill_new) == len_ff) && (lhs < prod_ff)) begin
            latch_ff <= 1'b1;
         end
      end
   end

   // result slot: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_save_states    = latch_ff;
   assign rsp_distinct_count = 8'(distinct_ff);
   assign rsp_window_fill    = 8'(fill_ff);

endmodule

@@ test/sliding_window_distinct_counter_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_distinct_counter_unit_test
// Self-checking bench for the sliding-window distinct counter. A directed
// opener covers the key extremes, clears, window lengths out of range, a
// window shrunk while full and the sticky save latch; random phases follow,
// each under its own register setting and key pool. Every request transfer
// is run through a behavioral copy of the window and count table, and every
// response transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

// Behavioral window, count table and latch, plus the queue of predicted responses
class window_count_board;

   typedef struct packed {
      logic       save;
      logic [7:0] distinct;
      logic [7:0] fill;
   } window_counts_type;

   localparam int DEPTH = 128;

   window_counts_type expected_counts[$];
   int unsigned       errors;

   logic [7:0]  len_reg;
   logic [16:0] thr_reg;

   logic [31:0] key_ring[DEPTH];
   int          ring_head;
   int          ring_fill;
   logic [31:0] tab_key[DEPTH];
   int          tab_cnt[DEPTH];
   int          distinct;
   bit          latch;

   function new();
      errors  = 0;
      len_reg = swdc_pkg::WINDOW_LENGTH_RESET;
      thr_reg = swdc_pkg::UNIQUE_THRESHOLD_RESET;
      empty_window();
   endfunction

   function void empty_window();
      for (int i = 0; i < DEPTH; i++) begin
         key_ring[i] = '0;
         tab_key[i]  = '0;
         tab_cnt[i]  = 0;
      end
      ring_head = 0;
      ring_fill = 0;
      distinct  = 0;
      latch     = 1'b0;
   endfunction

   function void write_reg(logic index, logic [31:0] data);
      if (index == swdc_pkg::REG_WINDOW_LENGTH) begin
         len_reg = data[7:0];
      end else begin
         thr_reg = data[16:0];
      end
   endfunction

   // length 0 acts as 1, anything above the depth acts as the depth
   function int effective_len();
      if (len_reg == 8'd0) return 1;
      if (int'(len_reg) > DEPTH) return DEPTH;
      return int'(len_reg);
   endfunction

   function int find_entry(logic [31:0] key);
      for (int i = 0; i < DEPTH; i++) begin
         if (tab_cnt[i] != 0 && tab_key[i] == key) return i;
      end
      return -1;
   endfunction

   function void drop_oldest();
      int e;
      e = find_entry(key_ring[ring_head]);
      if (e >= 0) begin
         tab_cnt[e]--;
         if (tab_cnt[e] == 0) distinct--;
      end
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill--;
   endfunction

   function void add_key(logic [31:0] key);
      int          e;
      int          len;
      longint      lhs;
      longint      rhs;
      len = effective_len();
      // a push drops at most one key, even when the window was shrunk
      if (ring_fill >= len && ring_fill > 0) drop_oldest();
      key_ring[(ring_head + ring_fill) % DEPTH] = key;
      ring_fill++;
      e = find_entry(key);
      if (e >= 0) begin
         tab_cnt[e]++;
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (tab_cnt[i] == 0) begin
               tab_key[i] = key;
               tab_cnt[i] = 1;
               distinct++;
               break;
            end
         end
      end
      // latch test only on an exact fill match
      if (!latch && ring_fill == len) begin
         lhs = longint'(distinct) * 65536;
         rhs = longint'(thr_reg) * longint'(len);
         if (lhs < rhs) latch = 1'b1;
      end
   endfunction

   // predict the response of one accepted request
   function void note_item(logic kind, logic [31:0] key);
      window_counts_type c;
      if (kind == swdc_pkg::KIND_CLEAR) begin
         empty_window();
      end else begin
         add_key(key);
      end
      c.save     = latch;
      c.distinct = distinct[7:0];
      c.fill     = ring_fill[7:0];
      expected_counts.insert(expected_counts.size(), c);
   endfunction

   function void check_result(logic save, logic [7:0] dcount, logic [7:0] fill);
      window_counts_type c;
      if (expected_counts.size() == 0) begin
         $display("%0t: response with none pending: save=%0d distinct=%0d fill=%0d",
                  $time, save, dcount, fill);
         errors++;
         return;
      end
      c = expected_counts.pop_front();
      if (c.save !== save) begin
         $display("%0t: save_states expected %0d actual %0d", $time, c.save, save);
         errors++;
      end
      if (c.distinct !== dcount) begin
         $display("%0t: distinct_count expected %0d actual %0d", $time, c.distinct, dcount);
         errors++;
      end
      if (c.fill !== fill) begin
         $display("%0t: window_fill expected %0d actual %0d", $time, c.fill, fill);
         errors++;
      end
   endfunction

endclass

module sliding_window_distinct_counter_unit_test;
   import swdc_pkg::*;

   localparam int WIN_DEPTH    = 128;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_EVERY   = 5000;
   localparam int TAIL_CYCLES  = 16;
   localparam int PHASE_ITEMS  = 180;
   localparam int PHASE_COUNT  = 7;

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_PUSH;
   logic [31:0] req_event_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_save_states;
   logic [7:0]  rsp_distinct_count;
   logic [7:0]  rsp_window_fill;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int          cycle_count = 0;
   bit          pressure_armed = 1'b0;

   window_count_board counts_board = new();

   sliding_window_distinct_counter_unit #(
      .WINDOW_MAX(WIN_DEPTH),
      .KEY_BITS  (32)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_event_key     (req_event_key),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_save_states   (rsp_save_states),
      .rsp_distinct_count(rsp_distinct_count),
      .rsp_window_fill   (rsp_window_fill),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // check the response before noting the request of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            counts_board.check_result(rsp_save_states, rsp_distinct_count, rsp_window_fill);
         end
         if (req_valid && req_ready) begin
            counts_board.note_item(req_kind, req_event_key);
         end
      end
   end

   // response side: stall patterns plus long hold-offs to back up the block
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          since_hold;
      bit          pressure_done;
      mode          = RX_STEADY;
      mode_left     = 0;
      hold_left     = 0;
      since_hold    = 0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 &&
             ((pressure_armed && !pressure_done) || since_hold >= HOLD_EVERY)) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = pressure_armed;
            since_hold    = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            since_hold++;
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
               RX_STEADY: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // offer one request and hold it until the transfer
   task automatic send_item(input logic kind, input logic [31:0] key);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_event_key <= key;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid, let the last transfer be noted, then wait for every response
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (counts_board.expected_counts.size() != 0) @(posedge clock);
   endtask

   // setup cycle, then access cycle; the register takes the write at pready
   task automatic csr_write(input logic index, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      counts_board.write_reg(index, data);
   endtask

   task automatic set_window(input logic [31:0] len, input logic [31:0] thr);
      csr_write(REG_WINDOW_LENGTH, len);
      csr_write(REG_UNIQUE_THRESHOLD, thr);
   endtask

   // random traffic from a key pool sized for this phase, sent in bursts
   task automatic run_random_phase(input int n_items);
      logic [31:0] pool[256];
      int          pool_n;
      int          clear_odds;
      int          gap_max;
      int          done;
      int          burst;
      int          gap;
      int          pick;
      logic [31:0] key;
      logic        kind;
      case ($urandom_range(0, 2))
         0:       pool_n = $urandom_range(1, 4);
         1:       pool_n = $urandom_range(5, 30);
         default: pool_n = $urandom_range(31, 256);
      endcase
      for (int i = 0; i < 256; i++) pool[i] = $urandom;
      // clear about once per few window lengths so the latch can re-arm
      clear_odds = 3 * counts_board.effective_len() + 10;
      gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      done       = 0;
      while (done < n_items) begin
         burst = $urandom_range(1, 16);
         for (int b = 0; b < burst && done < n_items; b++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               key = pick[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
            end else if (pick < 7) begin
               key = $urandom;
            end else begin
               key = pool[$urandom_range(0, pool_n - 1)];
            end
            kind = ($urandom_range(0, clear_odds - 1) == 0) ? KIND_CLEAR : KIND_PUSH;
            send_item(kind, key);
            done++;
         end
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      logic [31:0] len_cfg[PHASE_COUNT];
      logic [31:0] thr_cfg[PHASE_COUNT];
      len_cfg = '{128, 1, 255, 7, 0, 100, 0};
      thr_cfg = '{65536, 0, 131071, 40000, 65535, 6554, 0};
      len_cfg[PHASE_COUNT-1] = $urandom_range(0, 255);
      thr_cfg[PHASE_COUNT-1] = $urandom_range(0, 131071);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: key extremes and a clear
      send_item(KIND_PUSH, 32'h0000_0000);
      send_item(KIND_PUSH, 32'hFFFF_FFFF);
      send_item(KIND_CLEAR, 32'h0000_0000);
      drain_results();

      // short window at half threshold: latch sets on one key, stays through eviction
      set_window(3, 32768);
      repeat (3) send_item(KIND_PUSH, 32'hA5A5_A5A5);
      send_item(KIND_PUSH, 32'h5A5A_5A5A);
      send_item(KIND_CLEAR, 32'hFFFF_FFFF);
      send_item(KIND_PUSH, 32'h0000_0001);
      send_item(KIND_PUSH, 32'h0000_0002);
      send_item(KIND_PUSH, 32'h0000_0001);
      send_item(KIND_PUSH, 32'h0000_0002);
      drain_results();

      // length 0 acts as 1; window shrunk while full keeps its fill
      set_window(0, 65536);
      send_item(KIND_PUSH, 32'h0000_0007);
      send_item(KIND_CLEAR, 32'h0000_0000);
      send_item(KIND_PUSH, 32'h0000_0007);
      send_item(KIND_PUSH, 32'h0000_0008);
      drain_results();

      // threshold above one, beyond the Q0.16 range
      csr_write(REG_UNIQUE_THRESHOLD, 131071);
      send_item(KIND_PUSH, 32'h0000_0009);
      drain_results();

      // length beyond the depth, zero threshold
      set_window(255, 0);
      send_item(KIND_PUSH, 32'hFFFF_0000);
      send_item(KIND_PUSH, 32'h0000_FFFF);
      drain_results();

      // random phases, window state carried over between them
      pressure_armed = 1'b1;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_window(len_cfg[p], thr_cfg[p]);
         run_random_phase(PHASE_ITEMS);
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (counts_board.errors == 0 && counts_board.expected_counts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
